// ===== hw/rtl/lp2p_pkg.sv =====
`default_nettype none

package lp2p_pkg;

    // sizes of the coefficient store and the result
    localparam int CoefWidth  = 32;
    localparam int PixelWidth = 12;
    localparam int CoefCount  = 28;
    localparam int ExtCount   = 16;
    localparam int IdxW       = 5;
    localparam int StoreW     = (CoefWidth < 32) ? CoefWidth : 32;

    // image size registers
    localparam int SizeW = 13;
    localparam logic [SizeW-1:0] ColsReset = 13'd640;
    localparam logic [SizeW-1:0] RowsReset = 13'd480;

    // register indexes on the configuration port
    localparam logic CfgCols = 1'b0;
    localparam logic CfgRows = 1'b1;

    // input word kinds
    localparam logic CmdProject = 1'b0;
    localparam logic CmdWrite   = 1'b1;

    // one in Q16.16
    localparam logic signed [31:0] QOne = 32'sd65536;

    // divider widths and pipeline depth
    localparam int ProdW     = 32 + SizeW + 1;
    localparam int DivW      = (ProdW > 32 + PixelWidth) ? ProdW : 32 + PixelWidth;
    localparam int DivStages = PixelWidth + 2;
    localparam int NumStages = DivStages + 9;

    // stream widths, whole bytes
    localparam int InW  = ((IdxW + 4 * 32 + 7) / 8) * 8;
    localparam int OutW = ((2 * PixelWidth + 7) / 8) * 8;

    typedef logic signed [31:0] q16_t;

    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] idx;
        q16_t            value;
    } coef_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lp2p_coef_table.sv =====
`default_nettype none

module lp2p_coef_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lp2p_pkg::coef_wr_t wr,
    output lp2p_pkg::q16_t          coef [lp2p_pkg::CoefCount]
);

    logic [lp2p_pkg::StoreW-1:0] table_reg [lp2p_pkg::CoefCount];

    // single write port, out of range slots dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lp2p_pkg::CoefCount; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (wr.en && (32'(wr.idx) < lp2p_pkg::CoefCount))
        begin
            table_reg[wr.idx] <= wr.value[lp2p_pkg::StoreW-1:0];
        end
    end

    // every entry read in parallel, sign extended
    always_comb
    begin
        for (int i = 0; i < lp2p_pkg::CoefCount; i++)
        begin
            coef[i] = 32'($signed(table_reg[i]));
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lp2p_dot4.sv =====
`default_nettype none

module lp2p_dot4 (
    input  wire logic           clk,
    input  wire logic           ld_mul,
    input  wire logic           ld_sum,
    input  wire logic           ld_out,
    input  wire lp2p_pkg::q16_t coef [4],
    input  wire lp2p_pkg::q16_t vec  [4],
    output lp2p_pkg::q16_t      result
);

    logic signed [63:0] prod_reg [4];
    logic signed [65:0] sum_reg;
    logic signed [65:0] sum_next;
    logic signed [65:0] shr;
    logic signed [65:0] trunc_val;
    lp2p_pkg::q16_t     result_reg;
    lp2p_pkg::q16_t     result_next;

    // stage one: four exact Q32.32 products
    always_ff @(posedge clk)
    begin
        if (ld_mul)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= coef[i] * vec[i];
            end
        end
    end

    // stage two: exact sum
    always_comb
    begin
        sum_next = 66'(prod_reg[0]) + 66'(prod_reg[1]) + 66'(prod_reg[2])
                 + 66'(prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (ld_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    // stage three: truncate toward zero to Q16.16 and saturate
    always_comb
    begin
        shr = sum_reg >>> 16;
        if (sum_reg[65] && (sum_reg[15:0] != 16'd0))
        begin
            trunc_val = shr + 66'sd1;
        end
        else
        begin
            trunc_val = shr;
        end
        if ((trunc_val[65:31] == '0) || (trunc_val[65:31] == '1))
        begin
            result_next = trunc_val[31:0];
        end
        else if (trunc_val[65])
        begin
            result_next = 32'sh8000_0000;
        end
        else
        begin
            result_next = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lp2p_divider.sv =====
`default_nettype none

module lp2p_divider (
    input  wire logic                                clk,
    input  wire logic [lp2p_pkg::DivStages-1:0]      ld,
    input  wire logic signed [lp2p_pkg::ProdW-1:0]   num,
    input  wire lp2p_pkg::q16_t                      den,
    output logic [lp2p_pkg::PixelWidth-1:0]          quot,
    output logic                                     ovf,
    output logic                                     neg
);

    localparam int PW = lp2p_pkg::PixelWidth;
    localparam int DW = lp2p_pkg::DivW;

    logic [DW-1:0] nmag_reg;
    logic [DW-1:0] dmag_reg;
    logic          neg_reg [0:PW+1];
    logic          ovf_reg [1:PW+1];
    logic [DW-1:0] rem_reg [1:PW+1];
    logic [DW-1:0] dsh_reg [1:PW+1];
    logic [PW-1:0] q_reg   [1:PW+1];
    logic [lp2p_pkg::ProdW-1:0] num_abs;
    logic [31:0]                den_abs;

    // stage one: magnitudes and sign of the quotient
    always_comb
    begin
        num_abs = num[lp2p_pkg::ProdW-1] ? (-num) : num;
        den_abs = den[31] ? (-den) : den;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            nmag_reg   <= DW'(num_abs);
            dmag_reg   <= DW'(den_abs);
            neg_reg[0] <= num[lp2p_pkg::ProdW-1] ^ den[31];
        end
    end

    // stage two: quotient does not fit the pixel width
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            ovf_reg[1] <= (nmag_reg >= (dmag_reg << PW));
            rem_reg[1] <= nmag_reg;
            dsh_reg[1] <= dmag_reg;
            q_reg[1]   <= '0;
            neg_reg[1] <= neg_reg[0];
        end
    end

    // restoring steps, one quotient bit per stage from the top
    for (genvar j = 1; j <= PW; j++)
    begin : g_step
        logic [DW-1:0] trial;
        logic          fits;

        assign trial = dsh_reg[j] << (PW - j);
        assign fits  = (rem_reg[j] >= trial);

        always_ff @(posedge clk)
        begin
            if (ld[j+1])
            begin
                rem_reg[j+1] <= fits ? (rem_reg[j] - trial) : rem_reg[j];
                q_reg[j+1]   <= q_reg[j] | (fits ? (PW'(1) << (PW - j)) : '0);
                dsh_reg[j+1] <= dsh_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    assign quot = q_reg[PW+1];
    assign ovf  = ovf_reg[PW+1];
    assign neg  = neg_reg[PW+1];

endmodule

`default_nettype wire

// ===== hw/rtl/lidar_point_to_pixel_projection_unit.sv =====
// throughput: one point word per cycle through the 23-stage pipeline while
//   m_axis_tready does not stall it, with one quotient bit per divider stage; a
//   coefficient write waits until the pipeline is empty
// reset: asynchronous active low; clears the coefficient table to zero, the image size
//   to 640 by 480 and every stage valid bit
`default_nettype none

module lidar_point_to_pixel_projection_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // coef_index, coef_value, point_x, point_y, point_z, zero pad
    input  wire logic [lp2p_pkg::InW-1:0]      s_axis_tdata,
    // command
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // pixel_col, pixel_row
    output logic [lp2p_pkg::OutW-1:0]          m_axis_tdata,
    // point_valid
    output logic                               m_axis_tuser,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_addr,
    input  wire logic [lp2p_pkg::SizeW-1:0]    cfg_data
);

    localparam int NS = lp2p_pkg::NumStages;
    localparam int PW = lp2p_pkg::PixelWidth;
    localparam int DS = lp2p_pkg::DivStages;

    logic [lp2p_pkg::SizeW-1:0] cols_reg;
    logic [lp2p_pkg::SizeW-1:0] rows_reg;
    logic [NS:1]                vld_reg;
    logic [NS:1]                ld;
    logic                       in_acc;
    logic                       pt_acc;
    lp2p_pkg::coef_wr_t         coef_wr;
    lp2p_pkg::q16_t             coef [lp2p_pkg::CoefCount];
    lp2p_pkg::q16_t             pt_reg [3];
    lp2p_pkg::q16_t             ext_vec [4];
    lp2p_pkg::q16_t             ext_coef [4][4];
    lp2p_pkg::q16_t             prj_coef [3][4];
    lp2p_pkg::q16_t             cam [4];
    lp2p_pkg::q16_t             hom [3];
    logic                       front;
    logic                       front_reg [5:7];
    logic                       ok_reg [8:NS-1];
    logic signed [lp2p_pkg::ProdW-1:0] num_col_reg;
    logic signed [lp2p_pkg::ProdW-1:0] num_row_reg;
    lp2p_pkg::q16_t             den_reg;
    logic [PW-1:0]              q_col;
    logic [PW-1:0]              q_row;
    logic                       ovf_col;
    logic                       ovf_row;
    logic                       neg_col;
    logic                       neg_row;
    logic                       col_ok;
    logic                       row_ok;
    logic                       res_valid_reg;
    logic [PW-1:0]              res_col_reg;
    logic [PW-1:0]              res_row_reg;

    // image size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= lp2p_pkg::ColsReset;
            rows_reg <= lp2p_pkg::RowsReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                lp2p_pkg::CfgCols: cols_reg <= cfg_data;
                lp2p_pkg::CfgRows: rows_reg <= cfg_data;
                default:           cols_reg <= cols_reg;
            endcase
        end
    end

    // stage load enables, a stage moves when it is empty or its successor moves
    always_comb
    begin
        ld[NS] = ~vld_reg[NS] | m_axis_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            ld[k] = ~vld_reg[k] | ld[k+1];
        end
    end

    // coefficient writes only into an empty pipeline
    assign s_axis_tready = ld[1] & ((s_axis_tuser == lp2p_pkg::CmdProject) || (vld_reg == '0));
    assign in_acc = s_axis_tvalid & s_axis_tready;
    assign pt_acc = in_acc & (s_axis_tuser == lp2p_pkg::CmdProject);

    assign coef_wr.en    = in_acc & (s_axis_tuser == lp2p_pkg::CmdWrite);
    assign coef_wr.idx   = s_axis_tdata[lp2p_pkg::IdxW-1:0];
    assign coef_wr.value = s_axis_tdata[lp2p_pkg::IdxW +: 32];

    lp2p_coef_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (coef_wr),
        .coef  (coef)
    );

    // valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[1])
            begin
                vld_reg[1] <= pt_acc;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (ld[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: point capture
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            pt_reg[0] <= s_axis_tdata[lp2p_pkg::IdxW + 32 +: 32];
            pt_reg[1] <= s_axis_tdata[lp2p_pkg::IdxW + 64 +: 32];
            pt_reg[2] <= s_axis_tdata[lp2p_pkg::IdxW + 96 +: 32];
        end
    end

    // coefficient rows
    always_comb
    begin
        ext_vec[0] = pt_reg[0];
        ext_vec[1] = pt_reg[1];
        ext_vec[2] = pt_reg[2];
        ext_vec[3] = lp2p_pkg::QOne;
        for (int r = 0; r < 4; r++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ext_coef[r][i] = coef[r * 4 + i];
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prj_coef[r][i] = coef[lp2p_pkg::ExtCount + r * 4 + i];
            end
        end
    end

    // stages 2 to 4: lidar to camera
    for (genvar r = 0; r < 4; r++)
    begin : g_ext
        lp2p_dot4 u_dot (
            .clk    (clk),
            .ld_mul (ld[2]),
            .ld_sum (ld[3]),
            .ld_out (ld[4]),
            .coef   (ext_coef[r]),
            .vec    (ext_vec),
            .result (cam[r])
        );
    end

    // in front when first and last camera components share a nonzero sign
    assign front = ((cam[0] > 0) && (cam[3] > 0)) || ((cam[0] < 0) && (cam[3] < 0));

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            front_reg[5] <= front;
        end
        if (ld[6])
        begin
            front_reg[6] <= front_reg[5];
        end
        if (ld[7])
        begin
            front_reg[7] <= front_reg[6];
        end
    end

    // stages 5 to 7: projection
    for (genvar r = 0; r < 3; r++)
    begin : g_prj
        lp2p_dot4 u_dot (
            .clk    (clk),
            .ld_mul (ld[5]),
            .ld_sum (ld[6]),
            .ld_out (ld[7]),
            .coef   (prj_coef[r]),
            .vec    (cam),
            .result (hom[r])
        );
    end

    // stage 8: scale by image size
    always_ff @(posedge clk)
    begin
        if (ld[8])
        begin
            num_col_reg <= hom[0] * $signed({1'b0, cols_reg});
            num_row_reg <= hom[1] * $signed({1'b0, rows_reg});
            den_reg     <= hom[2];
            ok_reg[8]   <= front_reg[7] && (hom[2] != 0);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 9; k <= NS - 1; k++)
        begin
            if (ld[k])
            begin
                ok_reg[k] <= ok_reg[k-1];
            end
        end
    end

    // stages 9 to 22: the two divisions
    lp2p_divider u_div_col (
        .clk  (clk),
        .ld   (ld[8+DS:9]),
        .num  (num_col_reg),
        .den  (den_reg),
        .quot (q_col),
        .ovf  (ovf_col),
        .neg  (neg_col)
    );

    lp2p_divider u_div_row (
        .clk  (clk),
        .ld   (ld[8+DS:9]),
        .num  (num_row_reg),
        .den  (den_reg),
        .quot (q_row),
        .ovf  (ovf_row),
        .neg  (neg_row)
    );

    // final stage: range checks and output word
    always_comb
    begin
        col_ok = !ovf_col && (!neg_col || (q_col == '0)) && (32'(q_col) < 32'(cols_reg));
        row_ok = !ovf_row && (!neg_row || (q_row == '0)) && (32'(q_row) < 32'(rows_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ld[NS])
        begin
            res_valid_reg <= ok_reg[NS-1] && col_ok && row_ok;
            res_col_reg   <= (ok_reg[NS-1] && col_ok && row_ok) ? q_col : '0;
            res_row_reg   <= (ok_reg[NS-1] && col_ok && row_ok) ? q_row : '0;
        end
    end

    assign m_axis_tvalid = vld_reg[NS];
    assign m_axis_tuser  = res_valid_reg;
    assign m_axis_tdata  = lp2p_pkg::OutW'({res_row_reg, res_col_reg});

    // checks
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid result with nonzero pixel");

    a_col_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (32'(res_col_reg) < 32'(cols_reg)))
        else $error("column outside image");

    a_row_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (32'(res_row_reg) < 32'(rows_reg)))
        else $error("row outside image");

    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_axis_tuser == lp2p_pkg::CmdWrite)) |-> (vld_reg == '0))
        else $error("coefficient write with points in flight");

endmodule

`default_nettype wire
